>>> rtl/core/yuvnpc_pkg.sv
// ----------------------------------------------------------------------------
// yuvnpc_pkg
// Shared types, constants and tables of the YUV nearest palette color unit.
// ----------------------------------------------------------------------------
package yuvnpc_pkg;

  typedef struct packed {
    logic [8:0] y2;
    logic [7:0] u;
    logic [7:0] v;
  } yuv_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  localparam logic FUNC_QUERY = 1'b0;
  localparam logic FUNC_LOAD  = 1'b1;

  localparam logic [1:0] CH_Y  = 2'd0;
  localparam logic [1:0] CH_U  = 2'd1;
  localparam logic [1:0] CH_V  = 2'd2;
  localparam logic [1:0] CH_WR = 2'd3;

  localparam logic signed [13:0] COEF_YR = 14'sd2104;
  localparam logic signed [13:0] COEF_YG = 14'sd4310;
  localparam logic signed [13:0] COEF_YB = 14'sd802;
  localparam logic signed [13:0] COEF_UR = -14'sd1214;
  localparam logic signed [13:0] COEF_UG = -14'sd2384;
  localparam logic signed [13:0] COEF_UB = 14'sd3598;
  localparam logic signed [13:0] COEF_VR = 14'sd3598;
  localparam logic signed [13:0] COEF_VG = -14'sd3013;
  localparam logic signed [13:0] COEF_VB = -14'sd585;

  localparam logic signed [22:0] OFS_Y  = 23'sd135168;
  localparam logic signed [22:0] OFS_UV = 23'sd1052672;

  localparam logic [7:0] Y_MAX  = 8'd235;
  localparam logic [7:0] UV_MAX = 8'd240;

  localparam logic [8:0] CUBE_FIRST = 9'd16;
  localparam logic [8:0] GREY_FIRST = 9'd232;
  localparam logic [7:0] GREY_BASE  = 8'd8;
  localparam logic [7:0] GREY_STEP  = 8'd10;
  localparam logic [2:0] CUBE_TOP   = 3'd5;

  localparam logic [17:0] DIST_MAX = 18'd239104;

  function automatic rgb_t sys_color(input logic [3:0] idx);
    rgb_t c;
    case (idx)
      4'd0:    c = '{8'd0,   8'd0,   8'd0};
      4'd1:    c = '{8'd187, 8'd0,   8'd0};
      4'd2:    c = '{8'd0,   8'd187, 8'd0};
      4'd3:    c = '{8'd187, 8'd187, 8'd0};
      4'd4:    c = '{8'd0,   8'd0,   8'd187};
      4'd5:    c = '{8'd187, 8'd0,   8'd187};
      4'd6:    c = '{8'd0,   8'd187, 8'd187};
      4'd7:    c = '{8'd187, 8'd187, 8'd187};
      4'd8:    c = '{8'd85,  8'd85,  8'd85};
      4'd9:    c = '{8'd255, 8'd85,  8'd85};
      4'd10:   c = '{8'd85,  8'd255, 8'd85};
      4'd11:   c = '{8'd255, 8'd255, 8'd85};
      4'd12:   c = '{8'd85,  8'd85,  8'd255};
      4'd13:   c = '{8'd255, 8'd85,  8'd255};
      4'd14:   c = '{8'd85,  8'd255, 8'd255};
      default: c = '{8'd255, 8'd255, 8'd255};
    endcase
    return c;
  endfunction

  function automatic logic [7:0] cube_level(input logic [2:0] d);
    logic [7:0] l;
    case (d)
      3'd0:    l = 8'd0;
      3'd1:    l = 8'd95;
      3'd2:    l = 8'd135;
      3'd3:    l = 8'd175;
      3'd4:    l = 8'd215;
      3'd5:    l = 8'd255;
      default: l = 8'd0;
    endcase
    return l;
  endfunction

endpackage

>>> rtl/core/yuv_nearest_palette_color_unit.sv
// ----------------------------------------------------------------------------
// yuv_nearest_palette_color_unit
// Nearest palette entry search of an RGB pixel under a weighted YUV metric.
// ----------------------------------------------------------------------------
// Slave stream: tuser[0] = func (0 query, 1 load), tdata = red, green, blue,
// entry_index from the lowest byte up. A load converts the color and writes
// it to slot entry_index (ignored when beyond the palette); it gives no
// transfer on the master side. A query gives one master transfer:
// nearest_wide, nearest_sixteen, nearest_eight, wide_distance. For a query,
// one shared 3-term multiply-add converts the pixel channel by channel, then
// the palette memory is read one entry a cycle through a read/square/compare
// pipeline. Ready is high only while the block is idle. After reset the
// block fills the palette with the 256-color terminal set, entry by entry
// through the same converter, and only then raises ready. A finished result
// waits in the output register while the master side stalls; a new item is
// still taken, but its result is held back until the previous one has been
// transferred.
// ----------------------------------------------------------------------------
module yuv_nearest_palette_color_unit #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // red, green, blue, entry_index
  input  logic [0:0]  s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // nearest_wide, nearest_sixteen,
                                     // nearest_eight, wide_distance, zero fill
);

  localparam int unsigned AW = $clog2(PALETTE_ENTRIES);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] CNT_LAST = CW'(PALETTE_ENTRIES - 1);
  localparam logic [CW-1:0] CNT_END  = CW'(PALETTE_ENTRIES);
  localparam logic [8:0] SLOT_LIMIT = 9'(PALETTE_ENTRIES);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_CONV   = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [1:0]    ch_q, ch_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          rd_v_q, rd_v_d;
  logic          sq_v_q;
  logic          m_tvalid_q, m_tvalid_d;
  logic [39:0]   m_tdata_q;

  logic       func_q;
  logic [7:0] red_q, green_q, blue_q, entry_q;
  logic [7:0] y_q, u_q, v_q;

  logic [2:0] cr_q, cg_q, cb_q;
  logic [7:0] grey_q;

  yuvnpc_pkg::yuv_t palette_mem [PALETTE_ENTRIES];
  yuvnpc_pkg::yuv_t rdata_q;
  logic [AW-1:0]    rd_idx_q, sq_idx_q;
  logic [16:0]      sq_y_q;
  logic [15:0]      sq_u_q, sq_v2_q;

  logic [AW-1:0] best_w_q, best_16_q, best_8_q;
  logic [17:0]   dist_w_q, dist_16_q, dist_8_q;

  logic             accept;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic             init_step;
  logic             out_load;
  logic             conv_wr;
  yuvnpc_pkg::rgb_t gen_rgb, conv_rgb;
  yuvnpc_pkg::yuv_t conv_yuv;

  logic signed [22:0] k_r, k_g, k_b, k_o;
  logic signed [22:0] x_r, x_g, x_b, conv_sum;
  logic [7:0]         conv_raw, conv_lim, conv_val;

  logic [8:0]  gen_idx;
  logic [8:0]  dy;
  logic [7:0]  du, dv;
  logic [8:0]  sq_idx9;
  logic [17:0] dist_sum;

  assign accept = s_axis_tvalid && s_axis_tready;

  // Reset palette generator.
  assign gen_idx = 9'(cnt_q);
  always_comb begin
    if (gen_idx < yuvnpc_pkg::CUBE_FIRST) begin
      gen_rgb = yuvnpc_pkg::sys_color(gen_idx[3:0]);
    end else if (gen_idx < yuvnpc_pkg::GREY_FIRST) begin
      gen_rgb = '{yuvnpc_pkg::cube_level(cr_q), yuvnpc_pkg::cube_level(cg_q),
                  yuvnpc_pkg::cube_level(cb_q)};
    end else begin
      gen_rgb = '{grey_q, grey_q, grey_q};
    end
  end

  // Shared converter: one YUV channel per cycle.
  assign conv_rgb = (state_q == S_INIT) ? gen_rgb : {red_q, green_q, blue_q};

  always_comb begin
    case (ch_q)
      yuvnpc_pkg::CH_Y: begin
        k_r = 23'(yuvnpc_pkg::COEF_YR);
        k_g = 23'(yuvnpc_pkg::COEF_YG);
        k_b = 23'(yuvnpc_pkg::COEF_YB);
        k_o = yuvnpc_pkg::OFS_Y;
        conv_lim = yuvnpc_pkg::Y_MAX;
      end
      yuvnpc_pkg::CH_U: begin
        k_r = 23'(yuvnpc_pkg::COEF_UR);
        k_g = 23'(yuvnpc_pkg::COEF_UG);
        k_b = 23'(yuvnpc_pkg::COEF_UB);
        k_o = yuvnpc_pkg::OFS_UV;
        conv_lim = yuvnpc_pkg::UV_MAX;
      end
      default: begin
        k_r = 23'(yuvnpc_pkg::COEF_VR);
        k_g = 23'(yuvnpc_pkg::COEF_VG);
        k_b = 23'(yuvnpc_pkg::COEF_VB);
        k_o = yuvnpc_pkg::OFS_UV;
        conv_lim = yuvnpc_pkg::UV_MAX;
      end
    endcase
    x_r = 23'($signed({1'b0, conv_rgb.r}));
    x_g = 23'($signed({1'b0, conv_rgb.g}));
    x_b = 23'($signed({1'b0, conv_rgb.b}));
    conv_sum = x_r * k_r + x_g * k_g + x_b * k_b + k_o;
    conv_raw = conv_sum[20:13];
    conv_val = (conv_raw > conv_lim) ? conv_lim : conv_raw;
  end

  assign conv_yuv.y2 = {1'b0, y_q} + {2'b00, y_q[7:1]};
  assign conv_yuv.u  = u_q;
  assign conv_yuv.v  = v_q;

  assign conv_wr = ((state_q == S_INIT) || (state_q == S_CONV)) && (ch_q != yuvnpc_pkg::CH_WR);

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    ch_d       = ch_q;
    cnt_d      = cnt_q;
    rd_v_d     = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = cnt_q[AW-1:0];
    init_step  = 1'b0;
    out_load   = 1'b0;
    s_axis_tready = 1'b0;
    case (state_q)
      S_INIT: begin
        if (ch_q == yuvnpc_pkg::CH_WR) begin
          mem_we    = 1'b1;
          init_step = 1'b1;
          ch_d      = yuvnpc_pkg::CH_Y;
          if (cnt_q == CNT_LAST) begin
            cnt_d   = '0;
            state_d = S_IDLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end else begin
          ch_d = ch_q + 1'b1;
        end
      end
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          ch_d    = yuvnpc_pkg::CH_Y;
          state_d = S_CONV;
        end
      end
      S_CONV: begin
        if (ch_q == yuvnpc_pkg::CH_WR) begin
          ch_d = yuvnpc_pkg::CH_Y;
          if (func_q == yuvnpc_pkg::FUNC_LOAD) begin
            mem_waddr = entry_q[AW-1:0];
            mem_we    = ({1'b0, entry_q} < SLOT_LIMIT);
            state_d   = S_IDLE;
          end else begin
            cnt_d   = '0;
            state_d = S_SEARCH;
          end
        end else begin
          ch_d = ch_q + 1'b1;
        end
      end
      S_SEARCH: begin
        if (cnt_q != CNT_END) begin
          rd_v_d = 1'b1;
          cnt_d  = cnt_q + 1'b1;
        end else if (!rd_v_q && !sq_v_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!m_tvalid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (out_load) begin
      m_tvalid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_tvalid_d = 1'b0;
    end else begin
      m_tvalid_d = m_tvalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      ch_q       <= yuvnpc_pkg::CH_Y;
      cnt_q      <= '0;
      rd_v_q     <= 1'b0;
      sq_v_q     <= 1'b0;
      m_tvalid_q <= 1'b0;
      cr_q       <= '0;
      cg_q       <= '0;
      cb_q       <= '0;
      grey_q     <= yuvnpc_pkg::GREY_BASE;
    end else begin
      state_q    <= state_d;
      ch_q       <= ch_d;
      cnt_q      <= cnt_d;
      rd_v_q     <= rd_v_d;
      sq_v_q     <= rd_v_q;
      m_tvalid_q <= m_tvalid_d;
      if (init_step) begin
        if (gen_idx >= yuvnpc_pkg::GREY_FIRST) begin
          grey_q <= grey_q + yuvnpc_pkg::GREY_STEP;
        end else if (gen_idx >= yuvnpc_pkg::CUBE_FIRST) begin
          if (cb_q == yuvnpc_pkg::CUBE_TOP) begin
            cb_q <= '0;
            if (cg_q == yuvnpc_pkg::CUBE_TOP) begin
              cg_q <= '0;
              cr_q <= cr_q + 1'b1;
            end else begin
              cg_q <= cg_q + 1'b1;
            end
          end else begin
            cb_q <= cb_q + 1'b1;
          end
        end
      end
    end
  end

  // Item capture and converted channels.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= s_axis_tuser[0];
      red_q   <= s_axis_tdata[7:0];
      green_q <= s_axis_tdata[15:8];
      blue_q  <= s_axis_tdata[23:16];
      entry_q <= s_axis_tdata[31:24];
    end
    if (conv_wr) begin
      case (ch_q)
        yuvnpc_pkg::CH_Y: y_q <= conv_val;
        yuvnpc_pkg::CH_U: u_q <= conv_val;
        default:          v_q <= conv_val;
      endcase
    end
  end

  // Palette memory.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      palette_mem[mem_waddr] <= conv_yuv;
    end
    rdata_q  <= palette_mem[cnt_q[AW-1:0]];
    rd_idx_q <= cnt_q[AW-1:0];
  end

  // Square stage.
  always_comb begin
    dy = (rdata_q.y2 >= conv_yuv.y2) ? rdata_q.y2 - conv_yuv.y2 : conv_yuv.y2 - rdata_q.y2;
    du = (rdata_q.u >= u_q) ? rdata_q.u - u_q : u_q - rdata_q.u;
    dv = (rdata_q.v >= v_q) ? rdata_q.v - v_q : v_q - rdata_q.v;
  end

  always_ff @(posedge clk_i) begin
    sq_y_q   <= 17'({9'd0, dy} * {9'd0, dy});
    sq_u_q   <= {8'd0, du} * {8'd0, du};
    sq_v2_q  <= {8'd0, dv} * {8'd0, dv};
    sq_idx_q <= rd_idx_q;
  end

  // Compare stage.
  assign dist_sum = {1'b0, sq_y_q} + {2'b00, sq_u_q} + {2'b00, sq_v2_q};
  assign sq_idx9  = 9'(sq_idx_q);

  always_ff @(posedge clk_i) begin
    if (sq_v_q) begin
      if (sq_idx9 < 9'd8) begin
        if ((sq_idx9 == 9'd0) || (dist_sum < dist_8_q)) begin
          best_8_q <= sq_idx_q;
          dist_8_q <= dist_sum;
        end
      end
      if (sq_idx9 < yuvnpc_pkg::CUBE_FIRST) begin
        if ((sq_idx9 == 9'd0) || (dist_sum < dist_16_q)) begin
          best_16_q <= sq_idx_q;
          dist_16_q <= dist_sum;
        end
      end else begin
        if ((sq_idx9 == yuvnpc_pkg::CUBE_FIRST) || (dist_sum < dist_w_q)) begin
          best_w_q <= sq_idx_q;
          dist_w_q <= dist_sum;
        end
      end
    end
    if (out_load) begin
      m_tdata_q <= {7'd0, dist_w_q, best_8_q[2:0], best_16_q[3:0], 8'(best_w_q)};
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

`ifndef SYNTHESIS
  a_pipe_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_v_q || sq_v_q) |-> (state_q == S_SEARCH))
    else $error("search pipeline active outside search");

  a_wide_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_q |-> (m_tdata_q[7:0] >= 8'd16))
    else $error("wide result below slot 16");

  a_wide_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_q |-> (m_tdata_q[32:15] <= yuvnpc_pkg::DIST_MAX))
    else $error("wide distance out of range");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_q) |-> ($past(state_q) == S_DONE))
    else $error("result raised outside done state");

  a_accept_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_CONV))
    else $error("accepted item did not start conversion");
`endif

endmodule
